// ----- rtl/tsw_pkg.sv -----
package tsw_pkg;

    localparam int MAX_RANK   = 4;
    localparam int ELEM_W     = 32;
    localparam int IDX_W      = 24;
    localparam int POS_W      = 12;
    localparam int EXT_W      = POS_W + 1;
    localparam int RANK_W     = 3;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = EXT_W;

    localparam logic [CFG_IDX_W-1:0] REG_RANK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXT2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EXT3   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_B = 3'd6;

    localparam int SETTLE_W = 3;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd4;

    typedef struct packed {
        logic [RANK_W-1:0]                  rank;
        logic [MAX_RANK-1:0][EXT_W-1:0]     ext;
        logic [MAX_RANK-1:0][IDX_W-1:0]     stride;
        logic                               err;
    } t_cfg;

endpackage

// ----- rtl/tsw_cfg.sv -----
module tsw_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output tsw_pkg::t_cfg                 o_cfg,
    output logic                          o_settled
);
    import tsw_pkg::*;

    localparam int P23_W = 2 * EXT_W;
    localparam int SAT_W = IDX_W + 1;
    localparam int Q1_W  = EXT_W + SAT_W;
    localparam logic [SAT_W-1:0] SAT_VAL = SAT_W'((1 << IDX_W) + 1);
    localparam logic [SAT_W-1:0] IDX_SPAN = SAT_W'(1 << IDX_W);
    localparam logic [EXT_W-1:0] EXT_MAX = EXT_W'(1 << POS_W);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_RANK);

    logic [RANK_W-1:0]              r_rank;
    logic [MAX_RANK-1:0][EXT_W-1:0] r_ext;
    logic [AXIS_W-1:0]              r_swap_a;
    logic [AXIS_W-1:0]              r_swap_b;
    logic [SETTLE_W-1:0]            r_settle;

    logic [RANK_W-1:0]              n1_rank;
    logic [MAX_RANK-1:0][EXT_W-1:0] n1_ext;
    logic [MAX_RANK-1:0][EXT_W-1:0] n1_odim;
    logic [RANK_W-1:0]              r1_rank;
    logic [MAX_RANK-1:0][EXT_W-1:0] r1_ext;
    logic [MAX_RANK-1:0][EXT_W-1:0] r1_odim;
    logic [AXIS_W-1:0]              r1_swap_a;
    logic [AXIS_W-1:0]              r1_swap_b;

    logic [P23_W-1:0]               r2_p23;
    logic [SAT_W-1:0]               n3_q;
    logic [SAT_W-1:0]               r3_q;
    logic [Q1_W-1:0]                r3_q1;
    logic [SAT_W-1:0]               n4_q1;
    logic [Q1_W-1:0]                n4_total;
    logic [MAX_RANK-1:0][IDX_W-1:0] n4_s;
    t_cfg                           n4_cfg;
    t_cfg                           r4_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= RANK_W'(2);
            r_ext    <= {MAX_RANK{EXT_W'(1)}};
            r_swap_a <= AXIS_W'(0);
            r_swap_b <= AXIS_W'(1);
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_we) begin
                r_settle <= SETTLE_CYCLES;
                case (i_cfg_idx)
                    REG_RANK:   r_rank   <= i_cfg_data[RANK_W-1:0];
                    REG_EXT0:   r_ext[0] <= i_cfg_data;
                    REG_EXT1:   r_ext[1] <= i_cfg_data;
                    REG_EXT2:   r_ext[2] <= i_cfg_data;
                    REG_EXT3:   r_ext[3] <= i_cfg_data;
                    REG_SWAP_A: r_swap_a <= i_cfg_data[AXIS_W-1:0];
                    REG_SWAP_B: r_swap_b <= i_cfg_data[AXIS_W-1:0];
                    default: begin
                    end
                endcase
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
        end
    end

    // effective rank and extents, then swapped output dims
    always_comb begin
        if (r_rank == '0) begin
            n1_rank = RANK_W'(1);
        end else if (r_rank > RANK_MAX) begin
            n1_rank = RANK_MAX;
        end else begin
            n1_rank = r_rank;
        end
        for (int d = 0; d < MAX_RANK; d++) begin
            if (RANK_W'(d) >= n1_rank || r_ext[d] == '0) begin
                n1_ext[d] = EXT_W'(1);
            end else if (r_ext[d] > EXT_MAX) begin
                n1_ext[d] = EXT_MAX;
            end else begin
                n1_ext[d] = r_ext[d];
            end
        end
        for (int d = 0; d < MAX_RANK; d++) begin
            if (AXIS_W'(d) == r_swap_a) begin
                n1_odim[d] = n1_ext[r_swap_b];
            end else if (AXIS_W'(d) == r_swap_b) begin
                n1_odim[d] = n1_ext[r_swap_a];
            end else begin
                n1_odim[d] = n1_ext[d];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_rank   <= n1_rank;
        r1_ext    <= n1_ext;
        r1_odim   <= n1_odim;
        r1_swap_a <= r_swap_a;
        r1_swap_b <= r_swap_b;
        r2_p23    <= r1_odim[2] * r1_odim[3];
        r3_q      <= n3_q;
        r3_q1     <= r1_odim[1] * n3_q;
        r4_cfg    <= n4_cfg;
    end

    // products saturate just above the index range so the overflow test stays exact
    always_comb begin
        if (r2_p23 > P23_W'(IDX_SPAN)) begin
            n3_q = SAT_VAL;
        end else begin
            n3_q = r2_p23[SAT_W-1:0];
        end
    end

    always_comb begin
        if (r3_q1 > Q1_W'(IDX_SPAN)) begin
            n4_q1 = SAT_VAL;
        end else begin
            n4_q1 = r3_q1[SAT_W-1:0];
        end
        n4_total = r1_odim[0] * n4_q1;
        n4_s[3] = IDX_W'(1);
        n4_s[2] = IDX_W'(r1_odim[3]);
        n4_s[1] = r3_q[IDX_W-1:0];
        n4_s[0] = r3_q1[IDX_W-1:0];
        n4_cfg.rank = r1_rank;
        n4_cfg.ext  = r1_ext;
        // stride of each input axis after the exchange
        for (int d = 0; d < MAX_RANK; d++) begin
            if (AXIS_W'(d) == r1_swap_a) begin
                n4_cfg.stride[d] = n4_s[r1_swap_b];
            end else if (AXIS_W'(d) == r1_swap_b) begin
                n4_cfg.stride[d] = n4_s[r1_swap_a];
            end else begin
                n4_cfg.stride[d] = n4_s[d];
            end
        end
        n4_cfg.err = (RANK_W'(r1_swap_a) >= r1_rank) || (RANK_W'(r1_swap_b) >= r1_rank) ||
                     (n4_total > Q1_W'(IDX_SPAN));
    end

    assign o_cfg     = r4_cfg;
    assign o_settled = (r_settle == '0);

endmodule

// ----- rtl/tensor_axis_swap_transpose_unit.sv -----
// Two-axis tensor transpose, streaming.
// Input channel (i_valid/o_ready, i_element) takes tensor elements in
// row-major order. Output channel (o_valid/i_ready) returns each element
// unchanged with its row-major index in the tensor whose axes swap_a and
// swap_b are exchanged, a last flag on the final element and an error flag.
// Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data); after a
// write, strides are rebuilt by a four-stage multiply chain and o_ready
// stays low until the settle counter has run down to zero.
// Throughput is one item per cycle while the receiver takes each result and
// no write is settling; three register stages (position counters, stride
// multiplies, four-way add) lie between acceptance of an item and o_valid.
// Reset (synchronous, active low) restores default registers, clears the
// position counters and empties the pipeline; o_ready rises once the settle
// counter has run down to zero after reset is released.
// When the receiver stalls, the whole pipeline holds and o_ready is low
// while the output register is full and not taken; at most 3 items wait
// inside.
module tensor_axis_swap_transpose_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tsw_pkg::ELEM_W-1:0]     i_element,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tsw_pkg::ELEM_W-1:0]     o_element_out,
    output logic [tsw_pkg::IDX_W-1:0]      o_out_index,
    output logic                           o_last,
    output logic                           o_config_error,
    input  logic                           i_cfg_we,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tsw_pkg::*;

    t_cfg                           cfg;
    logic                           settled;
    logic                           en;
    logic                           acc;

    logic [MAX_RANK-1:0][POS_W-1:0] r_pos;
    logic [MAX_RANK-1:0][POS_W-1:0] n_pos;
    logic [MAX_RANK-1:0][POS_W-1:0] coord;
    logic [MAX_RANK-1:0]            wrap;
    logic                           carry;
    logic                           n_last;

    logic                           r1_v;
    logic [MAX_RANK-1:0][POS_W-1:0] r1_coord;
    logic [ELEM_W-1:0]              r1_elem;
    logic                           r1_last;
    logic                           r1_err;

    logic                           r2_v;
    logic [MAX_RANK-1:0][IDX_W-1:0] r2_prod;
    logic [ELEM_W-1:0]              r2_elem;
    logic                           r2_last;
    logic                           r2_err;
    logic [IDX_W-1:0]               n_sum;

    logic                           r_out_v;
    logic [ELEM_W-1:0]              r_out_elem;
    logic [IDX_W-1:0]               r_out_idx;
    logic                           r_out_last;
    logic                           r_out_err;

    tsw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_settled  (settled)
    );

    assign en      = !r_out_v || i_ready;
    assign o_ready = en && settled;
    assign acc     = i_valid && o_ready;

    // innermost axis steps first, carry ripples outward
    always_comb begin
        carry = 1'b1;
        for (int d = MAX_RANK - 1; d >= 0; d--) begin
            if (RANK_W'(d) < cfg.rank) begin
                coord[d] = r_pos[d];
                wrap[d]  = ({1'b0, r_pos[d]} + EXT_W'(1)) >= cfg.ext[d];
                if (!carry) begin
                    n_pos[d] = r_pos[d];
                end else if (wrap[d]) begin
                    n_pos[d] = '0;
                end else begin
                    n_pos[d] = r_pos[d] + POS_W'(1);
                end
                carry = carry && wrap[d];
            end else begin
                coord[d] = '0;
                wrap[d]  = 1'b1;
                n_pos[d] = '0;
            end
        end
        n_last = carry;
    end

    always_comb begin
        n_sum = '0;
        for (int d = 0; d < MAX_RANK; d++) begin
            n_sum = n_sum + r2_prod[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (acc) begin
                r_pos <= n_pos;
            end
            if (en) begin
                r1_v    <= acc;
                r2_v    <= r1_v;
                r_out_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_coord <= coord;
            r1_elem  <= i_element;
            r1_last  <= n_last;
            r1_err   <= cfg.err;
            for (int d = 0; d < MAX_RANK; d++) begin
                r2_prod[d] <= IDX_W'(r1_coord[d] * cfg.stride[d]);
            end
            r2_elem    <= r1_elem;
            r2_last    <= r1_last;
            r2_err     <= r1_err;
            r_out_elem <= r2_elem;
            r_out_idx  <= r2_err ? '0 : n_sum;
            r_out_last <= r2_last;
            r_out_err  <= r2_err;
        end
    end

    assign o_valid        = r_out_v;
    assign o_element_out  = r_out_elem;
    assign o_out_index    = r_out_idx;
    assign o_last         = r_out_last;
    assign o_config_error = r_out_err;

endmodule
